### rtl/cfci_pkg.sv
// Shared constants, types and face tables for the cell face corner lookup.
`timescale 1ns / 1ps

package cfci_pkg;

   localparam int CELL_TYPE_W   = 3;
   localparam int NODE_COUNT_W  = 11;
   localparam int FACE_W        = 3;
   localparam int CORNER_W      = 10;
   localparam int COUNT_W       = 3;
   localparam int STATUS_W      = 2;

   localparam logic [NODE_COUNT_W-1:0] MAX_NODE_COUNT = 11'd1024;
   localparam logic [NODE_COUNT_W-1:0] SERENDIPITY_QUAD_NODES = 11'd8;
   localparam logic [NODE_COUNT_W-1:0] SERENDIPITY_HEX_NODES  = 11'd20;

   // Largest nodes per edge that a lattice can have within the node limit.
   localparam int SQUARE_ROOT_LIMIT = 32;
   localparam int CUBE_ROOT_LIMIT   = 10;
   localparam int EDGE_W            = 6;

   localparam logic [CELL_TYPE_W-1:0] CT_TRI   = 3'd0;
   localparam logic [CELL_TYPE_W-1:0] CT_QUAD  = 3'd1;
   localparam logic [CELL_TYPE_W-1:0] CT_TET   = 3'd2;
   localparam logic [CELL_TYPE_W-1:0] CT_PRISM = 3'd3;
   localparam logic [CELL_TYPE_W-1:0] CT_HEX   = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_BAD_COUNT    = 2'd1,
      ST_UNKNOWN_TYPE = 2'd2,
      ST_BAD_FACE     = 2'd3
   } status_type;

   typedef logic [CORNER_W-1:0] corner_type;

   localparam logic [2:0] TRI_FACES [3][2] = '{
      '{3'd0, 3'd1}, '{3'd1, 3'd2}, '{3'd2, 3'd0}};
   localparam logic [2:0] QUAD_FACES [4][2] = '{
      '{3'd0, 3'd1}, '{3'd1, 3'd2}, '{3'd2, 3'd3}, '{3'd3, 3'd0}};
   localparam logic [2:0] TET_FACES [4][3] = '{
      '{3'd1, 3'd2, 3'd3}, '{3'd0, 3'd3, 3'd2},
      '{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd2, 3'd1}};
   localparam logic [2:0] PRISM_FACES [5][4] = '{
      '{3'd0, 3'd2, 3'd1, 3'd0}, '{3'd3, 3'd4, 3'd5, 3'd0},
      '{3'd0, 3'd1, 3'd4, 3'd3}, '{3'd1, 3'd2, 3'd5, 3'd4},
      '{3'd2, 3'd0, 3'd3, 3'd5}};
   localparam logic [2:0] HEX_FACES [6][4] = '{
      '{3'd1, 3'd0, 3'd3, 3'd2}, '{3'd0, 3'd1, 3'd5, 3'd4},
      '{3'd1, 3'd2, 3'd6, 3'd5}, '{3'd2, 3'd3, 3'd7, 3'd6},
      '{3'd3, 3'd0, 3'd4, 3'd7}, '{3'd4, 3'd5, 3'd6, 3'd7}};

   // Faces (edges in 2D) per cell type; 0 for an unknown type.
   function automatic logic [FACE_W:0] face_count(input logic [CELL_TYPE_W-1:0] ct);
      case (ct)
         CT_TRI:   face_count = 4'd3;
         CT_QUAD:  face_count = 4'd4;
         CT_TET:   face_count = 4'd4;
         CT_PRISM: face_count = 4'd5;
         CT_HEX:   face_count = 4'd6;
         default:  face_count = 4'd0;
      endcase
   endfunction

   // Corners on one face of a valid cell type and face.
   function automatic logic [COUNT_W-1:0] face_size(input logic [CELL_TYPE_W-1:0] ct,
                                                   input logic [FACE_W-1:0] face);
      case (ct)
         CT_TRI, CT_QUAD: face_size = 3'd2;
         CT_TET:          face_size = 3'd3;
         CT_PRISM:        face_size = (face < 3'd2) ? 3'd3 : 3'd4;
         CT_HEX:          face_size = 3'd4;
         default:         face_size = 3'd0;
      endcase
   endfunction

   // Slot in the corner vector for corner k of a face; 0 outside the tables.
   function automatic logic [2:0] face_slot(input logic [CELL_TYPE_W-1:0] ct,
                                            input logic [FACE_W-1:0] face,
                                            input logic [1:0] k);
      logic [2:0] slot;
      slot = 3'd0;
      case (ct)
         CT_TRI: begin
            if (face < 3'd3 && k < 2'd2) slot = TRI_FACES[face[1:0]][k[0]];
         end
         CT_QUAD: begin
            if (face < 3'd4 && k < 2'd2) slot = QUAD_FACES[face[1:0]][k[0]];
         end
         CT_TET: begin
            if (face < 3'd4 && k < 2'd3) slot = TET_FACES[face[1:0]][k];
         end
         CT_PRISM: begin
            if (face < 3'd5) slot = PRISM_FACES[face][k];
         end
         CT_HEX: begin
            if (face < 3'd6) slot = HEX_FACES[face][k];
         end
         default: slot = 3'd0;
      endcase
      return slot;
   endfunction

endpackage

### rtl/cfci_req_if.sv
// Query channel: cell type, node count and face number with valid/ready.
`timescale 1ns / 1ps

interface cfci_req_if import cfci_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CELL_TYPE_W-1:0]  cell_type;
   logic [NODE_COUNT_W-1:0] node_count;
   logic [FACE_W-1:0]       face_number;

   modport source (output valid, cell_type, node_count, face_number, input ready);
   modport sink   (input valid, cell_type, node_count, face_number, output ready);
endinterface

### rtl/cfci_rsp_if.sv
// Result channel: corner count, four corner indices and status with valid/ready.
`timescale 1ns / 1ps

interface cfci_rsp_if import cfci_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  corner_count;
   logic [CORNER_W-1:0] corner_a;
   logic [CORNER_W-1:0] corner_b;
   logic [CORNER_W-1:0] corner_c;
   logic [CORNER_W-1:0] corner_d;
   logic [STATUS_W-1:0] status;

   modport source (output valid, corner_count, corner_a, corner_b, corner_c, corner_d,
                   status, input ready);
   modport sink   (input valid, corner_count, corner_a, corner_b, corner_c, corner_d,
                   status, output ready);
endinterface

### rtl/cell_face_corner_indices.sv
// Cell face corner lookup: three-stage pipeline from face query to corner indices.
`timescale 1ns / 1ps

//  channel    direction  payload
//  req_chan   in         cell_type, node_count, face_number
//  rsp_chan   out        corner_count, corner_a..corner_d, status
//
//  An accepted query is loaded into stage 1 and moves on through stages 2
//  and 3; its result is then on rsp_chan. One transaction can enter every
//  cycle unless a stall backs up to stage 1. Stage 1 finds the lattice edge
//  length and the status, stage 2 builds the corner vector (one small
//  multiply), stage 3 picks the face corners into the output register.
//  Synchronous reset empties the pipeline. Each stage holds while the stage
//  after it is full and stalled, so a stall only backs up into the holes.

module cell_face_corner_indices import cfci_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   cfci_req_if.sink        req_chan,
   cfci_rsp_if.source      rsp_chan
);

   // ---------------------------------------------------------------
   // Stage handshake: a stage takes new data when empty or draining.
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   // ---------------------------------------------------------------
   // Stage 1: root search against constant squares and cubes, status.
   // ---------------------------------------------------------------
   logic [CELL_TYPE_W-1:0]  s1_type_in,    s1_type_ff;
   logic [NODE_COUNT_W-1:0] s1_nodes_in,   s1_nodes_ff;
   logic [FACE_W-1:0]       s1_face_in,    s1_face_ff;
   status_type              s1_status_in,  s1_status_ff;
   logic                    s1_lattice_in, s1_lattice_ff;
   logic [EDGE_W-1:0]       s1_edge_in,    s1_edge_ff;
   logic [NODE_COUNT_W-1:0] s1_edge_sq_in, s1_edge_sq_ff;

   logic [EDGE_W-1:0]       sq_root, cu_root;
   logic [NODE_COUNT_W-1:0] sq_val,  cu_sq_val;
   logic                    sq_hit,  cu_hit;

   always_comb begin
      s1_type_in  = req_chan.cell_type;
      s1_nodes_in = req_chan.node_count;
      s1_face_in  = req_chan.face_number;

      // Independent compares against constant lattice sizes.
      sq_hit  = 1'b0;
      sq_root = '0;
      sq_val  = '0;
      for (int r = 1; r <= SQUARE_ROOT_LIMIT; r++) begin
         if (s1_nodes_in == NODE_COUNT_W'(r * r)) begin
            sq_hit  = 1'b1;
            sq_root = EDGE_W'(r);
            sq_val  = NODE_COUNT_W'(r * r);
         end
      end
      cu_hit    = 1'b0;
      cu_root   = '0;
      cu_sq_val = '0;
      for (int r = 1; r <= CUBE_ROOT_LIMIT; r++) begin
         if (s1_nodes_in == NODE_COUNT_W'(r * r * r)) begin
            cu_hit    = 1'b1;
            cu_root   = EDGE_W'(r);
            cu_sq_val = NODE_COUNT_W'(r * r);
         end
      end

      s1_lattice_in = 1'b0;
      s1_edge_in    = sq_root;
      s1_edge_sq_in = sq_val;
      if (s1_type_in == CT_HEX) begin
         s1_edge_in    = cu_root;
         s1_edge_sq_in = cu_sq_val;
      end

      // Priority: unknown type, then node count, then face.
      s1_status_in = ST_OK;
      if (s1_type_in > CT_HEX) begin
         s1_status_in = ST_UNKNOWN_TYPE;
      end else if (s1_nodes_in == '0 || s1_nodes_in > MAX_NODE_COUNT) begin
         s1_status_in = ST_BAD_COUNT;
      end else if (s1_type_in == CT_QUAD) begin
         if (sq_hit) begin
            s1_lattice_in = 1'b1;
         end else if (s1_nodes_in != SERENDIPITY_QUAD_NODES) begin
            s1_status_in = ST_BAD_COUNT;
         end
      end else if (s1_type_in == CT_HEX) begin
         if (cu_hit) begin
            s1_lattice_in = 1'b1;
         end else if (s1_nodes_in != SERENDIPITY_HEX_NODES) begin
            s1_status_in = ST_BAD_COUNT;
         end
      end
      if (s1_status_in == ST_OK && {1'b0, s1_face_in} >= face_count(s1_type_in)) begin
         s1_status_in = ST_BAD_FACE;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: corner vector; identity unless the cell is a lattice.
   // ---------------------------------------------------------------
   logic [CELL_TYPE_W-1:0] s2_type_ff;
   logic [FACE_W-1:0]      s2_face_ff;
   status_type             s2_status_ff;
   corner_type             s2_corner_in [8];
   corner_type             s2_corner_ff [8];

   logic [NODE_COUNT_W-1:0]        edge_ext;
   logic [NODE_COUNT_W-1:0]        last_node, back_row, sq_last, sq_back;
   logic [NODE_COUNT_W+EDGE_W-1:0] top_start;

   always_comb begin
      edge_ext  = NODE_COUNT_W'(s1_edge_ff);
      last_node = s1_nodes_ff - 11'd1;
      back_row  = s1_nodes_ff - edge_ext;
      sq_last   = s1_edge_sq_ff - 11'd1;
      sq_back   = s1_edge_sq_ff - edge_ext;
      // Start of the top layer: m*m*(m-1).
      top_start = s1_edge_sq_ff * (s1_edge_ff - 6'd1);

      for (int i = 0; i < 8; i++) begin
         s2_corner_in[i] = CORNER_W'(i);
      end
      if (s1_lattice_ff && s1_type_ff == CT_QUAD) begin
         s2_corner_in[1] = CORNER_W'(edge_ext - 11'd1);
         s2_corner_in[2] = last_node[CORNER_W-1:0];
         s2_corner_in[3] = back_row[CORNER_W-1:0];
      end else if (s1_lattice_ff && s1_type_ff == CT_HEX) begin
         s2_corner_in[1] = CORNER_W'(edge_ext - 11'd1);
         s2_corner_in[2] = sq_last[CORNER_W-1:0];
         s2_corner_in[3] = sq_back[CORNER_W-1:0];
         s2_corner_in[4] = top_start[CORNER_W-1:0];
         s2_corner_in[5] = CORNER_W'(top_start[CORNER_W-1:0] + edge_ext[CORNER_W-1:0]
                                     - 10'd1);
         s2_corner_in[6] = last_node[CORNER_W-1:0];
         s2_corner_in[7] = back_row[CORNER_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: pick the face corners; zero everything on error.
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0] s3_count_in,  s3_count_ff;
   corner_type         s3_corner_in [4];
   corner_type         s3_corner_ff [4];
   status_type         s3_status_ff;

   always_comb begin
      s3_count_in = '0;
      for (int k = 0; k < 4; k++) begin
         s3_corner_in[k] = '0;
      end
      if (s2_status_ff == ST_OK) begin
         s3_count_in = face_size(s2_type_ff, s2_face_ff);
         for (int k = 0; k < 4; k++) begin
            if (COUNT_W'(k) < s3_count_in) begin
               s3_corner_in[k] = s2_corner_ff[face_slot(s2_type_ff, s2_face_ff, 2'(k))];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Registers: valid bits reset, payload loads on advance.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_type_ff    <= s1_type_in;
         s1_nodes_ff   <= s1_nodes_in;
         s1_face_ff    <= s1_face_in;
         s1_status_ff  <= s1_status_in;
         s1_lattice_ff <= s1_lattice_in;
         s1_edge_ff    <= s1_edge_in;
         s1_edge_sq_ff <= s1_edge_sq_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_type_ff   <= s1_type_ff;
         s2_face_ff   <= s1_face_ff;
         s2_status_ff <= s1_status_ff;
         s2_corner_ff <= s2_corner_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_count_ff  <= s3_count_in;
         s3_corner_ff <= s3_corner_in;
         s3_status_ff <= s2_status_ff;
      end
   end

   // Drive the result channel straight from the output register.
   assign rsp_chan.valid        = s3_valid_ff;
   assign rsp_chan.corner_count = s3_count_ff;
   assign rsp_chan.corner_a     = s3_corner_ff[0];
   assign rsp_chan.corner_b     = s3_corner_ff[1];
   assign rsp_chan.corner_c     = s3_corner_ff[2];
   assign rsp_chan.corner_d     = s3_corner_ff[3];
   assign rsp_chan.status       = STATUS_W'(s3_status_ff);

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != STATUS_W'(ST_OK) |->
         rsp_chan.corner_count == '0 && rsp_chan.corner_a == '0 &&
         rsp_chan.corner_b == '0 && rsp_chan.corner_c == '0 && rsp_chan.corner_d == '0)
      else $error("error result carries nonzero corners");

   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STATUS_W'(ST_OK) |->
         rsp_chan.corner_count == 3'd2 || rsp_chan.corner_count == 3'd3 ||
         rsp_chan.corner_count == 3'd4)
      else $error("ok result with bad corner count");

   a_edge_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.corner_count == 3'd2 |->
         rsp_chan.corner_c == '0 && rsp_chan.corner_d == '0)
      else $error("edge result with nonzero upper corners");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(s2_status_ff))
      else $error("stage 2 lost data under stall");

endmodule

### tb/sv/cell_face_corner_indices_tb.sv
// Self-checking testbench for the cell face corner lookup.
`timescale 1ns / 1ps

// Queries go in over req_chan and corner results come back over rsp_chan.
// First a short directed table runs. Then about nine hundred random queries
// follow, most of them well-formed cells and some of them noise. Each
// accepted query queues its expected result. A table row gives that result
// where it is typed in; otherwise the local face corner lookup below works
// it out. Both channels idle at random, with stretches at full rate.

module cell_face_corner_indices_tb;
   import cfci_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_QUERIES = 925;
   localparam int DRAIN_CYCLES  = 10;
   localparam int PAUSE_AT      = 400;

   // Cell type codes beyond the hex; all of them are unknown to the block.
   localparam logic [CELL_TYPE_W-1:0] CT_BAD_FIRST = 3'd5;
   localparam logic [CELL_TYPE_W-1:0] CT_BAD_LAST  = 3'd7;

   typedef struct packed {
      logic [COUNT_W-1:0] corner_count;
      corner_type         corner_a;
      corner_type         corner_b;
      corner_type         corner_c;
      corner_type         corner_d;
      status_type         status;
   } corner_result_type;

   typedef struct packed {
      logic                    typed;
      logic [CELL_TYPE_W-1:0]  cell_type;
      logic [NODE_COUNT_W-1:0] node_count;
      logic [FACE_W-1:0]       face_number;
      corner_result_type       want;
   } query_row_type;

   // Faces per known cell type: triangle, quad, tet, prism, hex.
   localparam int FACE_COUNT [5] = '{3, 4, 4, 5, 6};

   // Corner slots of each face, one octal digit per slot, first corner on the left.
   // For triangles, tets and prisms a slot is the node itself; for quads and
   // hexes it picks from the lattice corner vector.
   localparam logic [11:0] FACE_SLOTS [5][6] = '{
      '{12'o0100, 12'o1200, 12'o2000, 12'o0000, 12'o0000, 12'o0000},
      '{12'o0100, 12'o1200, 12'o2300, 12'o3000, 12'o0000, 12'o0000},
      '{12'o1230, 12'o0320, 12'o0130, 12'o0210, 12'o0000, 12'o0000},
      '{12'o0210, 12'o3450, 12'o0143, 12'o1254, 12'o2035, 12'o0000},
      '{12'o1032, 12'o0154, 12'o1265, 12'o2376, 12'o3047, 12'o4567}};

   localparam int FACE_SIZE [5][6] = '{
      '{2, 2, 2, 0, 0, 0},
      '{2, 2, 2, 2, 0, 0},
      '{3, 3, 3, 3, 0, 0},
      '{3, 3, 4, 4, 4, 0},
      '{4, 4, 4, 4, 4, 4}};

   // Directed queries. Rows with typed set carry their result; the rest are predicted.
   localparam query_row_type DIRECTED [25] = '{
      '{1'b1, CT_TRI,      11'd3,    3'd0, '{3'd2, 10'd0, 10'd1, 10'd0, 10'd0, ST_OK}},
      // tiny triangle is still accepted
      '{1'b1, CT_TRI,      11'd1,    3'd2, '{3'd2, 10'd2, 10'd0, 10'd0, 10'd0, ST_OK}},
      '{1'b1, CT_TRI,      11'd1024, 3'd3, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_FACE}},
      // single-node quad collapses every corner onto node 0
      '{1'b1, CT_QUAD,     11'd1,    3'd2, '{3'd2, 10'd0, 10'd0, 10'd0, 10'd0, ST_OK}},
      '{1'b0, CT_QUAD,     11'd4,    3'd1, '0},
      '{1'b0, CT_QUAD,     11'd1024, 3'd3, '0},
      // serendipity quad
      '{1'b1, CT_QUAD,     11'd8,    3'd2, '{3'd2, 10'd2, 10'd3, 10'd0, 10'd0, ST_OK}},
      '{1'b1, CT_QUAD,     11'd5,    3'd0, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_COUNT}},
      '{1'b1, CT_QUAD,     11'd9,    3'd4, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_FACE}},
      '{1'b1, CT_TET,      11'd4,    3'd0, '{3'd3, 10'd1, 10'd2, 10'd3, 10'd0, ST_OK}},
      '{1'b1, CT_TET,      11'd2047, 3'd3, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_COUNT}},
      '{1'b1, CT_TET,      11'd4,    3'd4, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_FACE}},
      '{1'b1, CT_PRISM,    11'd6,    3'd0, '{3'd3, 10'd0, 10'd2, 10'd1, 10'd0, ST_OK}},
      '{1'b1, CT_PRISM,    11'd6,    3'd4, '{3'd4, 10'd2, 10'd0, 10'd3, 10'd5, ST_OK}},
      '{1'b1, CT_PRISM,    11'd6,    3'd5, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_FACE}},
      '{1'b1, CT_HEX,      11'd1,    3'd5, '{3'd4, 10'd0, 10'd0, 10'd0, 10'd0, ST_OK}},
      '{1'b0, CT_HEX,      11'd8,    3'd0, '0},
      '{1'b0, CT_HEX,      11'd27,   3'd2, '0},
      '{1'b0, CT_HEX,      11'd1000, 3'd5, '0},
      // serendipity hex
      '{1'b1, CT_HEX,      11'd20,   3'd5, '{3'd4, 10'd4, 10'd5, 10'd6, 10'd7, ST_OK}},
      '{1'b1, CT_HEX,      11'd21,   3'd0, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_COUNT}},
      // a bad count outranks a bad face
      '{1'b1, CT_HEX,      11'd0,    3'd7, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_COUNT}},
      '{1'b1, CT_TRI,      11'd1025, 3'd0, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_BAD_COUNT}},
      '{1'b1, CT_BAD_FIRST, 11'd4,   3'd0, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_UNKNOWN_TYPE}},
      // an unknown type outranks everything
      '{1'b1, CT_BAD_LAST, 11'd0,    3'd7, '{3'd0, 10'd0, 10'd0, 10'd0, 10'd0, ST_UNKNOWN_TYPE}}};

   logic clock;
   logic reset;

   cfci_req_if req_chan ();
   cfci_rsp_if rsp_chan ();

   cell_face_corner_indices dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Expected results in order of acceptance, plus the one for the query on offer.
   corner_result_type expected_corners [$];
   corner_result_type offered_corners;
   int                fail_count = 0;
   bit                sender_burst = 1'b0;
   int                hold_cycles = 0;
   int                burst_cycles = 0;

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Work out the corners of one face the way the block should.
   function automatic corner_result_type lookup_face_corners(
         input logic [CELL_TYPE_W-1:0]  ct,
         input logic [NODE_COUNT_W-1:0] nodes,
         input logic [FACE_W-1:0]       face);
      int unsigned       vert [8];
      int unsigned       n;
      int unsigned       m;
      int unsigned       s;
      logic [11:0]       slots;
      corner_result_type res;
      res = '0;
      n = 32'(nodes);
      m = 0;
      for (int i = 0; i < 8; i++) vert[i] = i;
      if (ct > CT_HEX) begin
         res.status = ST_UNKNOWN_TYPE;
      end else if (n == 0 || n > MAX_NODE_COUNT) begin
         res.status = ST_BAD_COUNT;
      end else if (ct == CT_QUAD || ct == CT_HEX) begin
         // edge length of a square or cube lattice, 0 if n is neither
         for (int unsigned r = 1; r <= 32; r++) begin
            if (((ct == CT_QUAD) ? r * r : r * r * r) == n) m = r;
         end
         if (m == 0) begin
            if (n != ((ct == CT_QUAD) ? SERENDIPITY_QUAD_NODES : SERENDIPITY_HEX_NODES))
               res.status = ST_BAD_COUNT;
         end else if (ct == CT_QUAD) begin
            vert[1] = m - 1;
            vert[2] = n - 1;
            vert[3] = n - m;
         end else begin
            s = m * m * (m - 1);
            vert[1] = m - 1;
            vert[2] = m * m - 1;
            vert[3] = m * (m - 1);
            vert[4] = s;
            vert[5] = s + m - 1;
            vert[6] = n - 1;
            vert[7] = n - m;
         end
      end
      if (res.status == ST_OK && face >= FACE_COUNT[ct]) res.status = ST_BAD_FACE;
      if (res.status == ST_OK) begin
         slots = FACE_SLOTS[ct][face];
         res.corner_count = COUNT_W'(FACE_SIZE[ct][face]);
         res.corner_a = CORNER_W'(vert[slots[11:9]]);
         res.corner_b = CORNER_W'(vert[slots[8:6]]);
         if (res.corner_count > 2) res.corner_c = CORNER_W'(vert[slots[5:3]]);
         if (res.corner_count > 3) res.corner_d = CORNER_W'(vert[slots[2:0]]);
      end
      return res;
   endfunction

   // Idle cycles before a query: mostly none or a few, now and then a long hole.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_burst || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Append one expectation at the tail of the queue.
   function automatic void queue_expected(input corner_result_type want);
      expected_corners = {expected_corners, want};
   endfunction

   // Offer one query and hold it until the block takes it.
   task automatic send_query(input logic [CELL_TYPE_W-1:0]  ct,
                             input logic [NODE_COUNT_W-1:0] nodes,
                             input logic [FACE_W-1:0]       face,
                             input corner_result_type       want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cell_type   <= ct;
      req_chan.node_count  <= nodes;
      req_chan.face_number <= face;
      offered_corners      <= want;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // First let the last accepted query be queued, then wait until every
   // queued result has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (expected_corners.size() != 0) @(posedge clock);
   endtask

   // Compare the result on rsp_chan with the oldest expectation, field by field.
   task automatic check_result(input corner_result_type want);
      if (rsp_chan.corner_count !== want.corner_count) begin
         $error("corner_count: expected %0d, got %0d", want.corner_count,
                rsp_chan.corner_count);
         fail_count++;
      end
      if (rsp_chan.corner_a !== want.corner_a) begin
         $error("corner_a: expected %0d, got %0d", want.corner_a, rsp_chan.corner_a);
         fail_count++;
      end
      if (rsp_chan.corner_b !== want.corner_b) begin
         $error("corner_b: expected %0d, got %0d", want.corner_b, rsp_chan.corner_b);
         fail_count++;
      end
      if (rsp_chan.corner_c !== want.corner_c) begin
         $error("corner_c: expected %0d, got %0d", want.corner_c, rsp_chan.corner_c);
         fail_count++;
      end
      if (rsp_chan.corner_d !== want.corner_d) begin
         $error("corner_d: expected %0d, got %0d", want.corner_d, rsp_chan.corner_d);
         fail_count++;
      end
      if (rsp_chan.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
         fail_count++;
      end
   endtask

   // Record accepted queries, check results, and drive the result-side ready.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) queue_expected(offered_corners);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_corners.size() == 0) begin
               $error("result transaction with no query outstanding");
               fail_count++;
            end else begin
               check_result(expected_corners.pop_front());
            end
         end
         // Pick the next stall or full-rate stretch once the current one ends.
         if (hold_cycles == 0 && burst_cycles == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) burst_cycles = $urandom_range(20, 80);
            else if (roll < 10) hold_cycles = $urandom_range(8, 40);
            else if (roll < 35) hold_cycles = $urandom_range(1, 3);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (burst_cycles > 0) burst_cycles--;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [CELL_TYPE_W-1:0]  ct;
      logic [NODE_COUNT_W-1:0] nodes;
      logic [FACE_W-1:0]       face;
      query_row_type           row;
      int unsigned             m;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.cell_type   <= '0;
      req_chan.node_count  <= '0;
      req_chan.face_number <= '0;
      offered_corners      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         send_query(row.cell_type, row.node_count, row.face_number,
                    row.typed ? row.want
                              : lookup_face_corners(row.cell_type, row.node_count,
                                                    row.face_number));
      end
      // hold off until the pipeline is empty before going random
      req_chan.valid <= 1'b0;
      wait_drained();

      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         if (i % 50 == 0) sender_burst = ($urandom_range(0, 2) == 0);
         if (i == PAUSE_AT) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         if ($urandom_range(0, 99) < 15) begin
            // noise: any type, any count, any face
            ct    = CELL_TYPE_W'($urandom_range(0, 7));
            nodes = NODE_COUNT_W'($urandom_range(0, 2047));
            face  = FACE_W'($urandom_range(0, 7));
         end else begin
            ct = CELL_TYPE_W'($urandom_range(CT_TRI, CT_HEX));
            if (ct == CT_QUAD) begin
               m = $urandom_range(1, 32);
               nodes = ($urandom_range(0, 7) == 0) ? SERENDIPITY_QUAD_NODES
                                                   : NODE_COUNT_W'(m * m);
            end else if (ct == CT_HEX) begin
               m = $urandom_range(1, 10);
               nodes = ($urandom_range(0, 7) == 0) ? SERENDIPITY_HEX_NODES
                                                   : NODE_COUNT_W'(m * m * m);
            end else if ($urandom_range(0, 3) == 0) begin
               nodes = NODE_COUNT_W'($urandom_range(1, 8));
            end else begin
               nodes = NODE_COUNT_W'($urandom_range(1, MAX_NODE_COUNT));
            end
            if ($urandom_range(0, 9) == 0) face = FACE_W'($urandom_range(0, 7));
            else face = FACE_W'($urandom_range(0, FACE_COUNT[ct] - 1));
         end
         send_query(ct, nodes, face, lookup_face_corners(ct, nodes, face));
      end
      req_chan.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Drop the run if it hangs.
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
